// File: rtl/lim_pkg.sv
// ----------------------------------------------------------------------------
// Limiter package
// Shared types, fixed-point constants and state codes of the soft knee limiter.
// ----------------------------------------------------------------------------
package lim_pkg;

  localparam int MIX_FRAC_BITS = 20;
  localparam int GAIN_FRAC     = 14;
  localparam int GAIN_W        = 16;
  localparam int SAMPLE_W      = 24;
  localparam int A_W           = 25;
  localparam int DIV_W         = A_W + 1;
  localparam int M_W           = MIX_FRAC_BITS + 1;
  localparam int PCM_W         = 16;
  localparam int CLIP_W        = 32;
  localparam int CNT_W         = $clog2(MIX_FRAC_BITS);
  localparam int RECIP_SHIFT   = MIX_FRAC_BITS + 4;
  localparam int RECIP_W       = MIX_FRAC_BITS + 1;
  localparam int QUEUE_AW      = 1;

  localparam int ONE_INT   = 1 << MIX_FRAC_BITS;
  localparam int T_INT     = (9 * ONE_INT + 5) / 10;
  localparam int E_INT     = (ONE_INT + 50) / 100;
  localparam int RECIP_INT = ((1 << RECIP_SHIFT) + 9) / 10;

  localparam logic [GAIN_W-1:0]  GAIN_RESET = 16'd13107;
  localparam logic [A_W-1:0]     KNEE_T     = A_W'(T_INT);
  localparam logic [A_W-1:0]     KNEE_E     = A_W'(E_INT);
  localparam logic [M_W-1:0]     FULL_SCALE = M_W'(ONE_INT);
  localparam logic [RECIP_W-1:0] RECIP_TEN  = RECIP_W'(RECIP_INT);
  localparam logic [14:0]        PCM_SCALE  = 15'd32767;
  localparam logic [CLIP_W-1:0]  CLIP_MAX   = '1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mix_sample;
    logic                       clear_stats;
  } in_item_t;

  typedef struct packed {
    logic signed [PCM_W-1:0] pcm_sample;
    logic                    knee_applied;
    logic [A_W-1:0]          peak_level;
    logic [CLIP_W-1:0]       clip_total;
  } out_item_t;

  typedef struct packed {
    logic           neg;
    logic           knee;
    logic           clear;
    logic [A_W-1:0] mag;
    logic [A_W-1:0] peak;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RECIP,
    ST_PCM
  } back_state_t;

endpackage

// File: rtl/lim_front.sv
// ----------------------------------------------------------------------------
// Limiter front end
// Takes in samples, applies the gain, tracks the peak and flags the knee.
// ----------------------------------------------------------------------------
module lim_front import lim_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_write,
  input  logic [GAIN_W-1:0] cfg_data,
  input  logic     push,
  output logic     full,
  input  in_item_t item,
  output logic     job_push,
  input  logic     job_full,
  output job_t     job
);

  logic [GAIN_W-1:0]   gain;
  logic                s1_valid;
  in_item_t            s1_item;
  logic [A_W-1:0]      peak;
  logic [SAMPLE_W-1:0] mag;
  logic [SAMPLE_W+GAIN_W-1:0] prod;
  logic [A_W:0]        scaled;
  logic [A_W-1:0]      a;
  logic [A_W-1:0]      peak_base;
  logic [A_W-1:0]      peak_next;
  logic                take;

  assign full     = s1_valid && job_full;
  assign take     = push && !full;
  assign job_push = s1_valid && !job_full;

  always_comb begin
    mag       = s1_item.mix_sample[SAMPLE_W-1] ? SAMPLE_W'(-s1_item.mix_sample)
                                              : s1_item.mix_sample;
    prod      = SAMPLE_W'(mag) * GAIN_W'(gain);
    scaled    = (A_W+1)'(prod >> GAIN_FRAC);
    a         = scaled[A_W] ? '1 : scaled[A_W-1:0];
    peak_base = s1_item.clear_stats ? '0 : peak;
    peak_next = (a > peak_base) ? a : peak_base;
    job.neg   = s1_item.mix_sample[SAMPLE_W-1];
    job.knee  = a > KNEE_T;
    job.clear = s1_item.clear_stats;
    job.mag   = a;
    job.peak  = peak_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain     <= GAIN_RESET;
      s1_valid <= 1'b0;
      peak     <= '0;
    end else begin
      if (cfg_write) begin
        gain <= cfg_data;
      end
      if (job_push) begin
        peak <= peak_next;
      end
      if (take) begin
        s1_valid <= 1'b1;
      end else if (job_push) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_item <= item;
    end
  end

endmodule

// File: rtl/lim_queue.sv
// ----------------------------------------------------------------------------
// Limiter job queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module lim_queue import lim_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  job_t wr_job,
  output logic q_full,
  input  logic rd,
  output job_t rd_job,
  output logic q_empty
);

  localparam int DEPTH = 1 << QUEUE_AW;

  job_t                slots [DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign q_full  = count == (QUEUE_AW+1)'(DEPTH);
  assign q_empty = count == '0;
  assign rd_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

endmodule

// File: rtl/lim_back.sv
// ----------------------------------------------------------------------------
// Limiter back end
// Runs the knee divider, scales to PCM, counts clamps and holds the result.
// ----------------------------------------------------------------------------
module lim_back import lim_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  job_t      rd_job,
  output logic      rd,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  back_state_t          state, state_next;
  job_t                 cur, cur_next;
  logic [DIV_W-1:0]     rem, rem_next;
  logic [DIV_W-1:0]     div, div_next;
  logic [MIX_FRAC_BITS-1:0] quo, quo_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic [M_W-1:0]       m, m_next;
  logic [CLIP_W-1:0]    clip, clip_next;
  logic                 out_valid, out_valid_next;
  out_item_t            out_next;
  logic [DIV_W:0]       rem2;
  logic                 ge;
  logic [MIX_FRAC_BITS+RECIP_W-1:0] rprod;
  logic [M_W-1:0]       mc;
  logic [M_W+14:0]      pprod;
  logic [14:0]          pcm_mag;

  assign empty = !out_valid;

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    rem_next       = rem;
    div_next       = div;
    quo_next       = quo;
    cnt_next       = cnt;
    m_next         = m;
    clip_next      = clip;
    out_valid_next = out_valid && !pop;
    out_next       = result;
    rd             = 1'b0;
    rem2           = {rem, 1'b0};
    ge             = rem2 >= {1'b0, div};
    rprod          = quo * RECIP_TEN;
    mc             = (m > FULL_SCALE) ? FULL_SCALE : m;
    pprod          = mc * PCM_SCALE;
    pcm_mag        = 15'(pprod >> MIX_FRAC_BITS);
    case (state)
      ST_IDLE: begin
        if (!q_empty && !out_valid) begin
          rd       = 1'b1;
          cur_next = rd_job;
          rem_next = DIV_W'(rd_job.mag) - DIV_W'(KNEE_T);
          div_next = DIV_W'(rd_job.mag) + DIV_W'(KNEE_E);
          quo_next = '0;
          cnt_next = '0;
          m_next   = M_W'(rd_job.mag);
          if (rd_job.clear) begin
            clip_next = '0;
          end
          state_next = rd_job.knee ? ST_DIV : ST_PCM;
        end
      end
      ST_DIV: begin
        rem_next = ge ? DIV_W'(rem2 - {1'b0, div}) : rem2[DIV_W-1:0];
        quo_next = {quo[MIX_FRAC_BITS-2:0], ge};
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(MIX_FRAC_BITS - 1)) begin
          state_next = ST_RECIP;
        end
      end
      ST_RECIP: begin
        m_next     = M_W'(KNEE_T) + M_W'(rprod >> RECIP_SHIFT);
        state_next = ST_PCM;
      end
      ST_PCM: begin
        if (m > FULL_SCALE && clip != CLIP_MAX) begin
          clip_next = clip + 1'b1;
        end
        out_next.pcm_sample   = cur.neg ? -PCM_W'(pcm_mag) : PCM_W'(pcm_mag);
        out_next.knee_applied = cur.knee;
        out_next.peak_level   = cur.peak;
        out_next.clip_total   = clip_next;
        out_valid_next        = 1'b1;
        state_next            = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      clip      <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      clip      <= clip_next;
    end
  end

  always_ff @(posedge clk) begin
    cur    <= cur_next;
    rem    <= rem_next;
    div    <= div_next;
    quo    <= quo_next;
    cnt    <= cnt_next;
    m      <= m_next;
    result <= out_next;
  end

endmodule

// File: rtl/soft_knee_output_limiter.sv
// ----------------------------------------------------------------------------
// Soft knee output limiter
// Gain, peak meter, soft knee, clamp counter and 16-bit PCM conversion.
// ----------------------------------------------------------------------------
// A sample pushed in is registered in the front end, where the gain is
// applied and the peak meter is updated, and then waits in a two-entry queue.
// The back end takes a sample below the knee through ST_IDLE and ST_PCM; one
// above the knee also passes ST_DIV, where the one-bit serial divider forms
// the knee quotient, and ST_RECIP. It starts the next sample once the previous
// result has been popped. The user must write the gain register through
// cfg_write and cfg_data only while no transfer is in flight; it is not enforced.
module soft_knee_output_limiter import lim_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [GAIN_W-1:0] cfg_data,
  input  logic              push,
  output logic              full,
  input  in_item_t          item,
  output logic              empty,
  input  logic              pop,
  output out_item_t         result
);

  logic job_push;
  logic job_full;
  job_t job;
  logic job_rd;
  job_t rd_job;
  logic q_empty;

  lim_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .item     (item),
    .job_push (job_push),
    .job_full (job_full),
    .job      (job)
  );

  lim_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (job_push),
    .wr_job (job),
    .q_full (job_full),
    .rd     (job_rd),
    .rd_job (rd_job),
    .q_empty(q_empty)
  );

  lim_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_empty(q_empty),
    .rd_job (rd_job),
    .rd     (job_rd),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// Soft knee output limiter testbench
// Sends samples through the push/full side and pops results through the
// empty/pop side. The expected results come from a predictor of the gain,
// peak meter, soft knee, clamp counter and PCM conversion. Directed samples,
// some of them with fixed results, come first, then random samples over
// several gain settings with idle and stall phases and a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lim_pkg::*;

  localparam logic [63:0] UNITY     = 64'd1 << MIX_FRAC_BITS;
  localparam logic [63:0] KNEE_AT   = (64'd9 * UNITY + 64'd5) / 64'd10;
  localparam logic [63:0] KNEE_EPS  = (UNITY + 64'd50) / 64'd100;
  localparam logic [63:0] PEAK_TOP  = (64'd1 << A_W) - 64'd1;
  localparam int          CYCLE_CAP = 600000;
  localparam int          HOLD_LEN  = 200;
  localparam int          BLOCKS    = 8;
  localparam int          PER_BLOCK = 82;

  typedef struct {
    logic        load_gain;
    logic [15:0] gain;
    in_item_t    din;
    logic        typed;
    out_item_t   want;
  } stim_row_t;

  typedef struct {
    logic      typed;
    out_item_t want;
  } typed_note_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_write = 1'b0;
  logic [GAIN_W-1:0] cfg_data  = '0;
  logic              push      = 1'b0;
  logic              full;
  in_item_t          item      = '0;
  logic              empty;
  logic              pop       = 1'b0;
  out_item_t         result;

  logic [GAIN_W-1:0] gain_copy;
  logic [A_W-1:0]    peak_copy;
  logic [CLIP_W-1:0] clips_copy;

  out_item_t   limiter_out_q[$];
  typed_note_t note_q[$];
  stim_row_t   directed_rows[$];

  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int unsigned hold_req      = 0;
  int unsigned hold_ack      = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;
  int unsigned errors        = 0;
  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned knee_hits     = 0;
  int unsigned gains_used    = 0;

  out_item_t   predicted;
  out_item_t   want_now;
  typed_note_t note_now;

  soft_knee_output_limiter DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("%0t: timeout with %0d results outstanding", $time, limiter_out_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic out_item_t limit_sample(input in_item_t s);
    logic [63:0] raw;
    logic [63:0] mag;
    logic [63:0] a;
    logic [63:0] q;
    logic [63:0] m;
    logic [63:0] pcm_mag;
    logic        neg;
    logic        knee;
    out_item_t   r;
    raw = {40'd0, s.mix_sample};
    neg = s.mix_sample[SAMPLE_W-1];
    mag = neg ? (64'h100_0000 - raw) : raw;
    if (s.clear_stats) begin
      peak_copy  = '0;
      clips_copy = '0;
    end
    a = (mag * {48'd0, gain_copy}) >> GAIN_FRAC;
    if (a > PEAK_TOP) a = PEAK_TOP;
    if (a > {39'd0, peak_copy}) peak_copy = a[A_W-1:0];
    if (a > KNEE_AT) begin
      q    = ((a - KNEE_AT) << MIX_FRAC_BITS) / (a + KNEE_EPS);
      m    = KNEE_AT + q / 64'd10;
      knee = 1'b1;
    end else begin
      m    = a;
      knee = 1'b0;
    end
    if (m > UNITY) begin
      m = UNITY;
      if (clips_copy != '1) clips_copy++;
    end
    pcm_mag = (m * 64'd32767) >> MIX_FRAC_BITS;
    r.pcm_sample   = neg ? -pcm_mag[PCM_W-1:0] : pcm_mag[PCM_W-1:0];
    r.knee_applied = knee;
    r.peak_level   = peak_copy;
    r.clip_total   = clips_copy;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      gain_copy  = GAIN_RESET;
      peak_copy  = '0;
      clips_copy = '0;
    end else begin
      if (cfg_write) gain_copy = cfg_data;
      if (push && !full) begin
        predicted = limit_sample(item);
        if (note_q.size() != 0) begin
          note_now = note_q.pop_front();
          limiter_out_q.push_back(note_now.typed ? note_now.want : predicted);
        end else begin
          limiter_out_q.push_back(predicted);
        end
      end
      if (pop && !empty) begin
        results_seen++;
        if (result.knee_applied) knee_hits++;
        if (limiter_out_q.size() == 0) begin
          errors++;
          if (errors <= 20)
            $display({"%0t: unexpected transfer: expected nothing, ",
                      "got pcm %0d knee %0d peak %0d clips %0d"},
                     $time, result.pcm_sample, result.knee_applied, result.peak_level,
                     result.clip_total);
        end else begin
          want_now = limiter_out_q.pop_front();
          if (result.pcm_sample !== want_now.pcm_sample ||
              result.knee_applied !== want_now.knee_applied ||
              result.peak_level !== want_now.peak_level ||
              result.clip_total !== want_now.clip_total) begin
            errors++;
            if (errors <= 20)
              $display({"%0t: mismatch: expected pcm %0d knee %0d peak %0d clips %0d, ",
                        "got pcm %0d knee %0d peak %0d clips %0d"},
                       $time, want_now.pcm_sample, want_now.knee_applied,
                       want_now.peak_level, want_now.clip_total, result.pcm_sample,
                       result.knee_applied, result.peak_level, result.clip_total);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_LEN;
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void add_row(input logic load, input logic [15:0] g, input int smp,
                                  input logic clr, input logic typed, input int pcm,
                                  input logic kn, input int pk);
    stim_row_t r;
    r.load_gain              = load;
    r.gain                   = g;
    r.din.mix_sample         = smp[SAMPLE_W-1:0];
    r.din.clear_stats        = clr;
    r.typed                  = typed;
    r.want.pcm_sample        = pcm[PCM_W-1:0];
    r.want.knee_applied      = kn;
    r.want.peak_level        = pk[A_W-1:0];
    r.want.clip_total        = '0;
    directed_rows.push_back(r);
  endfunction

  function automatic in_item_t pick_sample();
    int unsigned sel;
    logic [63:0] centre;
    logic [63:0] mag;
    in_item_t    s;
    sel = $urandom_range(99);
    if (sel < 35) begin
      s.mix_sample = SAMPLE_W'($urandom());
    end else if (sel < 55 && gain_copy != 0) begin
      centre = (KNEE_AT << GAIN_FRAC) / {48'd0, gain_copy};
      mag    = centre + 64'd4096 - 64'($urandom_range(8192));
      if (mag > 64'h7F_FFFF) mag = 64'h7F_FFFF;
      s.mix_sample = $urandom_range(1) ? -mag[SAMPLE_W-1:0] : mag[SAMPLE_W-1:0];
    end else if (sel < 70) begin
      case ($urandom_range(6))
        0:       s.mix_sample = 24'h80_0000;
        1:       s.mix_sample = 24'h7F_FFFF;
        2:       s.mix_sample = '0;
        3:       s.mix_sample = 24'd1;
        4:       s.mix_sample = 24'hFF_FFFF;
        5:       s.mix_sample = 24'h10_0000;
        default: s.mix_sample = 24'hF0_0000;
      endcase
    end else begin
      mag = 64'($urandom_range(65535));
      s.mix_sample = $urandom_range(1) ? -mag[SAMPLE_W-1:0] : mag[SAMPLE_W-1:0];
    end
    s.clear_stats = ($urandom_range(19) == 0);
    return s;
  endfunction

  task automatic send_item(input in_item_t din, input logic typed, input out_item_t want);
    typed_note_t n;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    n.typed = typed;
    n.want  = want;
    note_q.push_back(n);
    push <= 1'b1;
    item <= din;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(negedge clk);
    while (limiter_out_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_gain(input logic [GAIN_W-1:0] g);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data  <= g;
    @(posedge clk);
    cfg_write <= 1'b0;
    gains_used++;
  endtask

  initial begin
    logic [GAIN_W-1:0] block_gain;
    add_row(0, 0,       0,  0, 1,      0, 0,      0);
    add_row(0, 0,  524288,  0, 0,      0, 0,      0);
    add_row(0, 0, 8388607,  0, 0,      0, 0,      0);
    add_row(0, 0, -8388608, 0, 0,      0, 0,      0);
    add_row(0, 0,      -1,  0, 0,      0, 0,      0);
    add_row(0, 0,       1,  0, 0,      0, 0,      0);
    add_row(1, 16384, 524288, 1, 1, 16383, 0, 524288);
    add_row(0, 0, -524288,  0, 1, -16383, 0, 524288);
    add_row(0, 0,  943718,  0, 0,      0, 0,      0);
    add_row(0, 0,  943719,  0, 0,      0, 0,      0);
    add_row(0, 0, 1048576,  0, 0,      0, 0,      0);
    add_row(0, 0, -1048576, 1, 0,      0, 0,      0);
    add_row(0, 0, 8388607,  0, 0,      0, 0,      0);
    add_row(0, 0, -8388608, 0, 0,      0, 0,      0);
    add_row(0, 0,      16,  1, 0,      0, 0,      0);
    add_row(1, 0, 8388607,  1, 1,      0, 0,      0);
    add_row(0, 0, -8388608, 0, 1,      0, 0,      0);
    add_row(1, 65535, -8388608, 1, 0,  0, 0,      0);
    add_row(0, 0, 8388607,  0, 0,      0, 0,      0);
    add_row(0, 0,       0,  0, 0,      0, 0,      0);
    add_row(0, 0,      -1,  0, 0,      0, 0,      0);
    add_row(0, 0,    4096,  1, 0,      0, 0,      0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].load_gain) write_gain(directed_rows[i].gain);
      send_item(directed_rows[i].din, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int b = 0; b < BLOCKS; b++) begin
      case (b)
        0:       block_gain = 16'd16384;
        1:       block_gain = 16'hFFFF;
        3:       block_gain = GAIN_RESET;
        6:       block_gain = 16'd32768;
        default: block_gain = GAIN_W'($urandom_range(65535));
      endcase
      write_gain(block_gain);
      case (b / 2)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 87; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 87; end
        default: begin send_idle_pct = 25; stall_pct = 25; end
      endcase
      for (int n = 0; n < PER_BLOCK; n++) begin
        if (b == 0 && n == 40) hold_req++;
        if (b == 5 && n == 40) wait_drained();
        send_item(pick_sample(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    $display("Sent %0d samples over %0d gain settings; %0d results checked, %0d %s",
             items_sent, gains_used, results_seen, knee_hits, "through the knee.");
    $display("Phases ran without idling, with sender gaps, receiver stalls and a long hold-off.");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
